FILE: rtl/core/uvat_pkg.sv
`timescale 1ns / 1ps
// Types, codes and helper functions shared by the UV affine transform core.
// No dependencies.
package uvat_pkg;

  // Order codes held in the order_mode register
  localparam logic [2:0] MODE_SRT = 3'd0;
  localparam logic [2:0] MODE_STR = 3'd1;
  localparam logic [2:0] MODE_RST = 3'd2;
  localparam logic [2:0] MODE_RTS = 3'd3;
  localparam logic [2:0] MODE_TSR = 3'd4;
  localparam logic [2:0] MODE_TRS = 3'd5;

  // Register indexes on the config port
  localparam logic [2:0] REG_ORDER_MODE = 3'd0;
  localparam logic [2:0] REG_SCALE_X    = 3'd1;
  localparam logic [2:0] REG_SCALE_Y    = 3'd2;
  localparam logic [2:0] REG_COS_THETA  = 3'd3;
  localparam logic [2:0] REG_SIN_THETA  = 3'd4;
  localparam logic [2:0] REG_SHIFT_X    = 3'd5;
  localparam logic [2:0] REG_SHIFT_Y    = 3'd6;
  localparam logic [2:0] REG_PIVOT_PAIR = 3'd7;

  typedef enum logic [1:0] {
    OP_SCALE,
    OP_ROTATE,
    OP_XLATE
  } uvat_op_e;

  // Coefficients seen by every operation slot
  typedef struct packed {
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [17:0] cos_theta;
    logic signed [17:0] sin_theta;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
  } uvat_coef_t;

  // Per-slot control: load enables of its two stages and the operation
  typedef struct packed {
    logic     en_mul;
    logic     en_fin;
    uvat_op_e op;
  } uvat_ctrl_t;

  // Operation that a slot (0..2) performs for a given order
  function automatic uvat_op_e slot_op(input logic [2:0] mode, input logic [1:0] slot);
    uvat_op_e ops [3];
    case (mode)
      MODE_SRT: ops = '{OP_SCALE,  OP_ROTATE, OP_XLATE};
      MODE_STR: ops = '{OP_SCALE,  OP_XLATE,  OP_ROTATE};
      MODE_RST: ops = '{OP_ROTATE, OP_SCALE,  OP_XLATE};
      MODE_RTS: ops = '{OP_ROTATE, OP_XLATE,  OP_SCALE};
      MODE_TSR: ops = '{OP_XLATE,  OP_SCALE,  OP_ROTATE};
      default:  ops = '{OP_XLATE,  OP_ROTATE, OP_SCALE};
    endcase
    case (slot)
      2'd0:    return ops[0];
      2'd1:    return ops[1];
      default: return ops[2];
    endcase
  endfunction

  // Clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [64:0] x);
    localparam logic signed [64:0] MaxVal = 65'sd2147483647;
    localparam logic signed [64:0] MinVal = -65'sd2147483648;
    if (x > MaxVal) return 32'sh7fffffff;
    if (x < MinVal) return 32'sh80000000;
    return x[31:0];
  endfunction

endpackage

FILE: rtl/core/uvat_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready stream interfaces for coordinate transactions in and out.
// No dependencies.
interface uvat_coord_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] coord_u;
  logic signed [31:0] coord_v;
  modport source (output valid, coord_u, coord_v, input ready);
  modport sink   (input valid, coord_u, coord_v, output ready);
endinterface

interface uvat_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_u;
  logic signed [31:0] new_v;
  modport source (output valid, new_u, new_v, input ready);
  modport sink   (input valid, new_u, new_v, output ready);
endinterface

FILE: rtl/core/uvat_op_stage.sv
`timescale 1ns / 1ps
// One operation slot: scale, rotate or translate over two register stages.
// Depends on uvat_pkg.
module uvat_op_stage import uvat_pkg::*; (
  input  logic               clk_i,
  input  uvat_ctrl_t         ctrl_i,
  input  uvat_coef_t         coef_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [31:0] a_o,
  output logic signed [31:0] b_o
);

  logic signed [31:0] mul_a, mul_b, sin_ext;
  logic signed [63:0] p0_d, p1_d, p2_d, p3_d;
  logic signed [63:0] p0_q, p1_q, p2_q, p3_q;
  logic signed [31:0] a_q, b_q;
  logic signed [64:0] sum_a, sum_b, res_a, res_b;
  logic signed [31:0] a_d, b_d, ao_q, bo_q;

  // Multiply stage: scale uses both 32-bit factors, rotate reuses them for cos
  always_comb begin
    sin_ext = 32'(coef_i.sin_theta);
    if (ctrl_i.op == OP_SCALE) begin
      mul_a = coef_i.scale_x;
      mul_b = coef_i.scale_y;
    end else begin
      mul_a = 32'(coef_i.cos_theta);
      mul_b = 32'(coef_i.cos_theta);
    end
    p0_d = 64'(a_i) * 64'(mul_a);
    p1_d = 64'(b_i) * 64'(mul_b);
    p2_d = 64'(b_i) * 64'(sin_ext);
    p3_d = 64'(a_i) * 64'(sin_ext);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_mul) begin
      p0_q <= p0_d;
      p1_q <= p1_d;
      p2_q <= p2_d;
      p3_q <= p3_d;
      a_q  <= a_i;
      b_q  <= b_i;
    end
  end

  // Finish stage: combine and shift by 16 (floor), or add the translation, then saturate
  always_comb begin
    if (ctrl_i.op == OP_ROTATE) begin
      sum_a = 65'(p0_q) - 65'(p2_q);
      sum_b = 65'(p3_q) + 65'(p1_q);
    end else begin
      sum_a = 65'(p0_q);
      sum_b = 65'(p1_q);
    end
    if (ctrl_i.op == OP_XLATE) begin
      res_a = 65'(a_q) + 65'(coef_i.shift_x);
      res_b = 65'(b_q) + 65'(coef_i.shift_y);
    end else begin
      res_a = sum_a >>> 16;
      res_b = sum_b >>> 16;
    end
    a_d = sat32(res_a);
    b_d = sat32(res_b);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_fin) begin
      ao_q <= a_d;
      bo_q <= b_d;
    end
  end

  assign a_o = ao_q;
  assign b_o = bo_q;

endmodule

FILE: rtl/core/uv_affine_transform_core.sv
`timescale 1ns / 1ps
// Top level of the UV affine transform core: config registers and pipeline.
// Depends on uvat_pkg, uvat_stream_if and uvat_op_stage.
//
// Usage:
// - coord_i carries (coord_u, coord_v) transactions in signed Q16.16; result_o
//   returns (new_u, new_v), one result transaction per input transaction, in order.
// - The APB port writes the eight registers at byte address 8*index (64-bit
//   data). Write only while the pipeline is empty.
// - Path: from the accepting edge to result valid, through eight
//   register stages: pivot subtract, three operation slots of two stages each
//   (multiply, then combine/shift/saturate), pivot add into the output register.
// - Throughput: one transaction per cycle unless the receiver stalls; each stage
//   loads whenever it is empty or the stage after it moves, so bubbles collapse under a stall.
// - When the receiver stalls, the filled stages hold; coord_i.ready drops
//   only once every stage holds a transaction.
// - Reset empties the pipeline and loads the register defaults: order TSR,
//   unit scale, cos 1.0, sin 0, no translation, pivot (0.5, 0.5).
module uv_affine_transform_core import uvat_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  uvat_coord_if.sink   coord_i,
  uvat_result_if.source result_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  localparam int unsigned NumStages = 8;

  // Config registers
  logic [2:0]         order_mode_q;
  logic signed [31:0] scale_x_q, scale_y_q, shift_x_q, shift_y_q;
  logic signed [17:0] cos_q, sin_q;
  logic signed [31:0] pivot_x_q, pivot_y_q;
  logic [2:0]         reg_idx;
  logic               cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_mode_q <= MODE_TSR;
      scale_x_q    <= 32'sd65536;
      scale_y_q    <= 32'sd65536;
      cos_q        <= 18'sd65536;
      sin_q        <= '0;
      shift_x_q    <= '0;
      shift_y_q    <= '0;
      pivot_x_q    <= 32'sd32768;
      pivot_y_q    <= 32'sd32768;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_ORDER_MODE: order_mode_q <= (pwdata[2:0] > MODE_TRS) ? MODE_TRS : pwdata[2:0];
        REG_SCALE_X:    scale_x_q    <= pwdata[31:0];
        REG_SCALE_Y:    scale_y_q    <= pwdata[31:0];
        REG_COS_THETA:  cos_q        <= pwdata[17:0];
        REG_SIN_THETA:  sin_q        <= pwdata[17:0];
        REG_SHIFT_X:    shift_x_q    <= pwdata[31:0];
        REG_SHIFT_Y:    shift_y_q    <= pwdata[31:0];
        REG_PIVOT_PAIR: begin
          pivot_x_q <= pwdata[31:0];
          pivot_y_q <= pwdata[63:32];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ORDER_MODE: prdata = {61'd0, order_mode_q};
      REG_SCALE_X:    prdata = {32'd0, scale_x_q};
      REG_SCALE_Y:    prdata = {32'd0, scale_y_q};
      REG_COS_THETA:  prdata = {46'd0, cos_q};
      REG_SIN_THETA:  prdata = {46'd0, sin_q};
      REG_SHIFT_X:    prdata = {32'd0, shift_x_q};
      REG_SHIFT_Y:    prdata = {32'd0, shift_y_q};
      default:        prdata = {pivot_y_q, pivot_x_q};
    endcase
  end

  uvat_coef_t coef;
  assign coef = '{scale_x:   scale_x_q,
                  scale_y:   scale_y_q,
                  cos_theta: cos_q,
                  sin_theta: sin_q,
                  shift_x:   shift_x_q,
                  shift_y:   shift_y_q};

  // Stage valids and load enables; a stage loads if empty or draining
  logic [NumStages-1:0] valid_q, en;

  always_comb begin
    en[NumStages-1] = !valid_q[NumStages-1] || result_o.ready;
    for (int i = NumStages - 2; i >= 0; i--) begin
      en[i] = !valid_q[i] || en[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= coord_i.valid;
      end
      for (int i = 1; i < NumStages; i++) begin
        if (en[i]) begin
          valid_q[i] <= valid_q[i-1];
        end
      end
    end
  end

  assign coord_i.ready = en[0];

  // Stage 0: subtract pivot
  logic signed [31:0] a0_q, b0_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      a0_q <= sat32(65'(coord_i.coord_u) - 65'(pivot_x_q));
      b0_q <= sat32(65'(coord_i.coord_v) - 65'(pivot_y_q));
    end
  end

  // Stages 1..6: three operation slots in the configured order
  logic signed [31:0] slot_a [4];
  logic signed [31:0] slot_b [4];
  uvat_ctrl_t         slot_ctrl [3];

  assign slot_a[0] = a0_q;
  assign slot_b[0] = b0_q;

  for (genvar s = 0; s < 3; s++) begin : g_slot
    assign slot_ctrl[s] = '{en_mul: en[2*s+1],
                            en_fin: en[2*s+2],
                            op:     slot_op(order_mode_q, 2'(s))};

    uvat_op_stage u_op (
      .clk_i  (clk_i),
      .ctrl_i (slot_ctrl[s]),
      .coef_i (coef),
      .a_i    (slot_a[s]),
      .b_i    (slot_b[s]),
      .a_o    (slot_a[s+1]),
      .b_o    (slot_b[s+1])
    );
  end

  // Stage 7: add pivot back into the output register
  logic signed [31:0] new_u_q, new_v_q;

  always_ff @(posedge clk_i) begin
    if (en[NumStages-1]) begin
      new_u_q <= sat32(65'(slot_a[3]) + 65'(pivot_x_q));
      new_v_q <= sat32(65'(slot_b[3]) + 65'(pivot_y_q));
    end
  end

  assign result_o.valid = valid_q[NumStages-1];
  assign result_o.new_u = new_u_q;
  assign result_o.new_v = new_v_q;

endmodule
